### rtl/sha256_pkg.sv
// sha256_pkg: shared types, command/status codes, round constants and
// sigma functions for the SHA-256 hasher. No dependencies.
package sha256_pkg;

	localparam int WordW      = 32;
	localparam int ChainWords = 8;
	localparam int BlkWords   = 16;
	localparam int Rounds     = 64;
	localparam int WinDepth   = 15;

	localparam logic [1:0] CMD_ABSORB  = 2'd0;
	localparam logic [1:0] CMD_FINISH  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       shift;
		logic       step;
		logic [5:0] rnd;
	} cmp_ctl_t;

	localparam word_t ROUND_K [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_H [ChainWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t bsig0(word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

### rtl/sha256_hasher.sv
// sha256_hasher: top level; command sequencer, block and chain RAMs.
// Depends on sha256_pkg, sha256_ram, sha256_sched, sha256_round.
//
// Byte-serial SHA-256. An absorb, restart or rejected transaction returns one
// result; absorbs stream at one per cycle while the result register drains.
// The 64th byte of a block starts a compression that holds off commands while
// it loads the chain from its RAM, runs 64 rounds at one per cycle, then adds
// back and writes the chain RAM. A finish writes the padding one word a cycle,
// runs one or two compressions, then reads the chain RAM for the eight digest
// words in turn, each word waiting for the result register to be free. The
// chain RAM has one read and one write port; the message block sits in a
// 16-word RAM read once per early round.
module sha256_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  sha256_pkg::cmd_t  cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output sha256_pkg::res_t  res
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_EMIT_RD, S_EMIT_WT
	} state_t;

	state_t      state_q;
	logic [3:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [3:0]  pad_idx_q;
	logic [2:0]  widx_q;
	logic [5:0]  fill_q;
	logic [63:0] total_q;
	logic        done_q;
	logic [23:0] asm_q;
	logic        fin_q;
	logic        last_blk_q;
	logic        pad_first_q;
	logic [7:0]  chain_vld_q;
	logic [2:0]  chain_raddr_q;
	logic        res_valid_q;
	res_t        res_q;

	logic        cmd_acc, res_free, res_load;
	logic        total_full, len_ovf, absorb_wr, pad_wr;
	res_t        res_next;
	cmp_ctl_t    ctl;
	word_t       chain_rdata, chain_word, chain_wdata, a_word, w;
	logic [2:0]  chain_raddr, chain_waddr;
	logic        chain_we;
	word_t       blk_rdata, blk_wdata, pad_word;
	logic [3:0]  blk_raddr, blk_waddr;
	logic        blk_we;
	logic [63:0] bit_len;

	assign res_free  = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == S_IDLE) && res_free;
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign total_full = &total_q;
	assign len_ovf    = |total_q[63:61];
	assign bit_len    = {total_q[60:0], 3'b000};

	assign chain_word = chain_vld_q[chain_raddr_q] ? chain_rdata : INIT_H[chain_raddr_q];

	always_comb begin
		case (state_q)
			S_LOAD, S_ADD:        chain_raddr = cnt_q[2:0];
			S_EMIT_RD, S_EMIT_WT: chain_raddr = widx_q;
			default:              chain_raddr = '0;
		endcase
	end

	assign chain_we    = (state_q == S_ADD) && (cnt_q != '0);
	assign chain_waddr = 3'(cnt_q - 4'd1);
	assign chain_wdata = chain_word + a_word;

	assign pad_word = {asm_q, 8'h00} | (32'h8000_0000 >> {fill_q[1:0], 3'b000});

	assign absorb_wr = cmd_acc && (cmd.command == CMD_ABSORB) && !done_q && !total_full &&
		(fill_q[1:0] == 2'd3);
	assign pad_wr = (state_q == S_PAD);

	always_comb begin
		blk_we    = absorb_wr || pad_wr;
		blk_waddr = pad_wr ? pad_idx_q : fill_q[5:2];
		if (!pad_wr) begin
			blk_wdata = {asm_q, cmd.data_byte};
		end else if (pad_first_q) begin
			blk_wdata = pad_word;
		end else if (last_blk_q && (pad_idx_q == 4'(BlkWords - 2))) begin
			blk_wdata = bit_len[63:32];
		end else if (last_blk_q && (pad_idx_q == 4'(BlkWords - 1))) begin
			blk_wdata = bit_len[31:0];
		end else begin
			blk_wdata = '0;
		end
	end

	assign blk_raddr = (state_q == S_ROUND) ? (rnd_q[3:0] + 4'd1) : '0;

	assign ctl.shift = ((state_q == S_LOAD) || (state_q == S_ADD)) && (cnt_q != '0);
	assign ctl.step  = (state_q == S_ROUND);
	assign ctl.rnd   = rnd_q;

	always_comb begin
		res_load = 1'b0;
		res_next = '{status: ST_OK, digest_word: '0, word_index: '0, last: 1'b1};
		if (cmd_acc) begin
			case (cmd.command)
				CMD_RESTART: begin
					res_load = 1'b1;
				end
				CMD_ABSORB: begin
					res_load = 1'b1;
					if (done_q) begin
						res_next.status = ST_DONE;
					end else if (total_full) begin
						res_next.status = ST_LIMIT;
					end
				end
				CMD_FINISH: begin
					if (done_q) begin
						res_load = 1'b1;
						res_next.status = ST_DONE;
					end else if (len_ovf) begin
						res_load = 1'b1;
						res_next.status = ST_LIMIT;
					end
				end
				default: begin
					res_load = 1'b0;
				end
			endcase
		end
		if ((state_q == S_EMIT_WT) && res_free) begin
			res_load = 1'b1;
			res_next.digest_word = chain_word;
			res_next.word_index  = widx_q;
			res_next.last        = (widx_q == 3'(ChainWords - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			rnd_q         <= '0;
			pad_idx_q     <= '0;
			widx_q        <= '0;
			fill_q        <= '0;
			total_q       <= '0;
			done_q        <= 1'b0;
			asm_q         <= '0;
			fin_q         <= 1'b0;
			last_blk_q    <= 1'b0;
			pad_first_q   <= 1'b0;
			chain_vld_q   <= '0;
			chain_raddr_q <= '0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			chain_raddr_q <= chain_raddr;
			if (res_load) begin
				res_valid_q <= 1'b1;
				res_q       <= res_next;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (chain_we) begin
				chain_vld_q[chain_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						case (cmd.command)
							CMD_RESTART: begin
								chain_vld_q <= '0;
								fill_q      <= '0;
								total_q     <= '0;
								done_q      <= 1'b0;
								asm_q       <= '0;
							end
							CMD_ABSORB: begin
								if (!done_q && !total_full) begin
									total_q <= total_q + 64'd1;
									fill_q  <= fill_q + 6'd1;
									case (fill_q[1:0])
										2'd0:    asm_q[23:16] <= cmd.data_byte;
										2'd1:    asm_q[15:8]  <= cmd.data_byte;
										2'd2:    asm_q[7:0]   <= cmd.data_byte;
										default: asm_q        <= '0;
									endcase
									if (&fill_q) begin
										state_q <= S_LOAD;
										cnt_q   <= '0;
										fin_q   <= 1'b0;
									end
								end
							end
							CMD_FINISH: begin
								if (!done_q && !len_ovf) begin
									state_q     <= S_PAD;
									pad_idx_q   <= fill_q[5:2];
									pad_first_q <= 1'b1;
									last_blk_q  <= (fill_q[5:2] < 4'(BlkWords - 2));
									fin_q       <= 1'b1;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					if (pad_idx_q == 4'(BlkWords - 1)) begin
						state_q <= S_LOAD;
						cnt_q   <= '0;
					end else begin
						pad_idx_q <= pad_idx_q + 4'd1;
					end
				end
				S_LOAD: begin
					if (cnt_q == 4'(ChainWords)) begin
						state_q <= S_ROUND;
						rnd_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_ROUND: begin
					if (rnd_q == 6'(Rounds - 1)) begin
						state_q <= S_ADD;
						cnt_q   <= '0;
					end else begin
						rnd_q <= rnd_q + 6'd1;
					end
				end
				S_ADD: begin
					if (cnt_q == 4'(ChainWords)) begin
						if (!fin_q) begin
							state_q <= S_IDLE;
						end else if (!last_blk_q) begin
							state_q    <= S_PAD;
							pad_idx_q  <= '0;
							last_blk_q <= 1'b1;
						end else begin
							state_q <= S_EMIT_RD;
							widx_q  <= '0;
						end
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WT;
				end
				S_EMIT_WT: begin
					if (res_free) begin
						if (widx_q == 3'(ChainWords - 1)) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
							fill_q  <= '0;
							asm_q   <= '0;
						end else begin
							state_q <= S_EMIT_RD;
							widx_q  <= widx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	sha256_ram #(.Width(WordW), .Depth(ChainWords)) u_chain_ram (
		.clk   (clk),
		.we    (chain_we),
		.waddr (chain_waddr),
		.wdata (chain_wdata),
		.raddr (chain_raddr),
		.rdata (chain_rdata)
	);

	sha256_ram #(.Width(WordW), .Depth(BlkWords)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	sha256_sched u_sched (
		.clk      (clk),
		.ctl      (ctl),
		.blk_word (blk_rdata),
		.w        (w)
	);

	sha256_round u_round (
		.clk       (clk),
		.ctl       (ctl),
		.load_word (chain_word),
		.w         (w),
		.a_word    (a_word)
	);

endmodule

### rtl/sha256_ram.sv
// sha256_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module sha256_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/sha256_sched.sv
// sha256_sched: message schedule window; passes block words for the first
// sixteen rounds, then expands. Depends on sha256_pkg.
module sha256_sched (
	input  logic                 clk,
	input  sha256_pkg::cmp_ctl_t ctl,
	input  sha256_pkg::word_t    blk_word,
	output sha256_pkg::word_t    w
);
	import sha256_pkg::*;

	word_t win_q [WinDepth];
	word_t wnext_q;

	assign w = (ctl.rnd < 6'(BlkWords)) ? blk_word : wnext_q;

	// window holds w[r-1] down to w[r-15]; next word precomputed a round early
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			win_q[0] <= w;
			for (int i = 1; i < WinDepth; i++) begin
				win_q[i] <= win_q[i-1];
			end
			wnext_q <= ssig1(win_q[0]) + win_q[5] + ssig0(win_q[13]) + win_q[14];
		end
	end

endmodule

### rtl/sha256_round.sv
// sha256_round: working variables a..h and the per-round compression step.
// Depends on sha256_pkg.
module sha256_round (
	input  logic                 clk,
	input  sha256_pkg::cmp_ctl_t ctl,
	input  sha256_pkg::word_t    load_word,
	input  sha256_pkg::word_t    w,
	output sha256_pkg::word_t    a_word
);
	import sha256_pkg::*;

	word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	word_t t1, t2;

	assign t1 = h_q + bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[ctl.rnd] + w;
	assign t2 = bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	assign a_word = a_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
			e_q <= f_q;
			f_q <= g_q;
			g_q <= h_q;
			h_q <= load_word;
		end else if (ctl.step) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
	end

endmodule

### rtl/sha256_chk.sv
// sha256_chk: port-level assertions for sha256_hasher, bound to the top level.
// Depends on sha256_pkg.
module sha256_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input sha256_pkg::cmd_t cmd,
	input logic             res_valid,
	input logic             res_ready,
	input sha256_pkg::res_t res
);
	import sha256_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |->
			(res.digest_word == '0) && (res.word_index == '0) && res.last)
		else $error("rejected transaction carries digest data");

	a_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |->
			(res.status == ST_OK) && (res.word_index != 3'(ChainWords - 1)))
		else $error("non-final result out of digest sequence");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.command == CMD_RESTART) |=>
			res_valid && (res.status == ST_OK) && res.last && (res.word_index == '0))
		else $error("restart did not answer next cycle");

	a_unused_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd.command != CMD_ABSORB) &&
			(cmd.command != CMD_FINISH) && (cmd.command != CMD_RESTART) |=> !res_valid)
		else $error("unused command produced a result");

endmodule

bind sha256_hasher sha256_chk u_sha256_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

### tb/testbench.sv
// testbench: self-checking bench for sha256_hasher; directed table then random messages,
// checked against table values or an in-bench SHA-256 model; random source/sink stalls.
// Depends on sha256_pkg (cmd_t, res_t, command and status codes) and the RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sha256_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RAND_ITEMS = 430;
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 250;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam int BOUNDARY_LENS [11] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 128};

	typedef struct packed {
		cmd_t         item;
		logic         fixed;
		logic [1:0]   st;
		logic [255:0] dg;
	} row_t;

	localparam int NROWS = 16;
	localparam row_t DIRECTED [NROWS] = '{
		{CMD_FINISH,  8'h00, 1'b1, ST_OK,
			256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
		{CMD_ABSORB,  8'h5a, 1'b1, ST_DONE, 256'h0},
		{CMD_FINISH,  8'h00, 1'b1, ST_DONE, 256'h0},
		{CMD_UNUSED,  8'hff, 1'b0, ST_OK,   256'h0},
		{CMD_RESTART, 8'h00, 1'b1, ST_OK,   256'h0},
		{CMD_ABSORB,  8'h61, 1'b1, ST_OK,   256'h0},
		{CMD_ABSORB,  8'h62, 1'b1, ST_OK,   256'h0},
		{CMD_ABSORB,  8'h63, 1'b1, ST_OK,   256'h0},
		{CMD_FINISH,  8'hff, 1'b1, ST_OK,
			256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
		{CMD_RESTART, 8'hff, 1'b1, ST_OK,   256'h0},
		{CMD_ABSORB,  8'h00, 1'b1, ST_OK,   256'h0},
		{CMD_ABSORB,  8'hff, 1'b1, ST_OK,   256'h0},
		{CMD_UNUSED,  8'h00, 1'b0, ST_OK,   256'h0},
		{CMD_FINISH,  8'h00, 1'b0, ST_OK,   256'h0},
		{CMD_ABSORB,  8'h80, 1'b1, ST_DONE, 256'h0},
		{CMD_RESTART, 8'h00, 1'b1, ST_OK,   256'h0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic res_valid;
	logic res_ready;
	res_t res;

	sha256_hasher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hash state tracked alongside the block
	logic [31:0] chain_h [8];
	logic [7:0]  msg_blk [64];
	int          blk_fill;
	logic [63:0] msg_len;
	logic        finished;

	res_t owed_results [$];
	int   fails = 0;
	int   burst_left = 0;

	function automatic logic [31:0] rotr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic void hash_init();
		int i;
		for (i = 0; i < 8; i++) chain_h[i] = H_INIT[i];
		for (i = 0; i < 64; i++) msg_blk[i] = 8'h00;
		blk_fill = 0;
		msg_len = '0;
		finished = 1'b0;
	endfunction

	function automatic void compress_blk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {msg_blk[4*i], msg_blk[4*i+1], msg_blk[4*i+2], msg_blk[4*i+3]};
		for (i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ K_TAB[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	function automatic res_t status_only(logic [1:0] s);
		res_t x;
		x = '0;
		x.status = s;
		x.last = 1'b1;
		return x;
	endfunction

	// results caused by one accepted transaction
	function automatic void hash_step(cmd_t c, output res_t r [$]);
		res_t x;
		logic [63:0] bit_len;
		int pos;
		int i;
		r = {};
		if (c.command == CMD_RESTART) begin
			hash_init();
			r.push_back(status_only(ST_OK));
		end else if (c.command == CMD_UNUSED) begin
			return;
		end else if (finished) begin
			r.push_back(status_only(ST_DONE));
		end else if (c.command == CMD_ABSORB) begin
			if (msg_len == '1) begin
				r.push_back(status_only(ST_LIMIT));
			end else begin
				msg_blk[blk_fill] = c.data_byte;
				msg_len++;
				blk_fill++;
				if (blk_fill == 64) begin
					compress_blk();
					blk_fill = 0;
				end
				r.push_back(status_only(ST_OK));
			end
		end else if (msg_len > 64'h1fff_ffff_ffff_ffff) begin
			r.push_back(status_only(ST_LIMIT));
		end else begin
			bit_len = msg_len << 3;
			pos = blk_fill;
			msg_blk[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				for (i = pos; i < 64; i++) msg_blk[i] = 8'h00;
				compress_blk();
				pos = 0;
			end
			for (i = pos; i < 56; i++) msg_blk[i] = 8'h00;
			for (i = 0; i < 8; i++) msg_blk[63-i] = bit_len[8*i +: 8];
			compress_blk();
			for (i = 0; i < 8; i++) begin
				x = '0;
				x.status = ST_OK;
				x.digest_word = chain_h[i];
				x.word_index = i[2:0];
				x.last = (i == 7);
				r.push_back(x);
			end
			finished = 1'b1;
			blk_fill = 0;
			for (i = 0; i < 64; i++) msg_blk[i] = 8'h00;
		end
	endfunction

	task automatic offer(cmd_t c, logic fixed = 1'b0, logic [1:0] st = ST_OK,
			logic [255:0] dg = '0);
		res_t r [$];
		res_t x;
		int i;
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 30);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		burst_left--;
		hash_step(c, r);
		if (fixed) begin
			r = {};
			if (c.command == CMD_FINISH && st == ST_OK) begin
				for (i = 0; i < 8; i++) begin
					x = '0;
					x.status = ST_OK;
					x.digest_word = dg[255 - 32*i -: 32];
					x.word_index = i[2:0];
					x.last = (i == 7);
					r.push_back(x);
				end
			end else begin
				r.push_back(status_only(st));
			end
		end
		foreach (r[i]) owed_results.push_back(r[i]);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	function automatic cmd_t mk(logic [1:0] op, logic [7:0] b);
		cmd_t c;
		c.command = op;
		c.data_byte = b;
		return c;
	endfunction

	// sink: random stall pattern plus one long hold-off to back the block up
	int   got_cnt = 0;
	int   hold_cnt = 0;
	logic held = 1'b0;
	int   mode = 0;
	int   mode_left = 0;
	res_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				got_cnt++;
				if (owed_results.size() == 0) begin
					$error("unexpected result: status %0d word %h index %0d last %0d",
						res.status, res.digest_word, res.word_index, res.last);
					fails++;
				end else begin
					want = owed_results.pop_front();
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						fails++;
					end
					if (res.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h", want.digest_word,
							res.digest_word);
						fails++;
					end
					if (res.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d", want.word_index,
							res.word_index);
						fails++;
					end
					if (res.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, res.last);
						fails++;
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res_ready <= 1'b0;
			end else if (!held && got_cnt >= HOLD_AFTER) begin
				held = 1'b1;
				hold_cnt = HOLD_CYCLES;
				res_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					2: res_ready <= ($urandom_range(0, 3) == 0);
					default: res_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int sent;
		int len;
		int i;
		logic cut;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		res_ready <= 1'b0;
		hash_init();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NROWS; i++)
			offer(DIRECTED[i].item, DIRECTED[i].fixed, DIRECTED[i].st, DIRECTED[i].dg);
		drain();

		sent = 0;
		while (sent < RAND_ITEMS) begin
			offer(mk(CMD_RESTART, 8'($urandom)));
			sent++;
			if ($urandom_range(0, 9) < 3)
				len = BOUNDARY_LENS[$urandom_range(0, 10)];
			else
				len = $urandom_range(0, 40);
			cut = 1'b0;
			for (int n = 0; n < len && !cut; n++) begin
				if ($urandom_range(0, 19) == 0)
					offer(mk(CMD_UNUSED, 8'($urandom)));
				offer(mk(CMD_ABSORB, 8'($urandom)));
				sent++;
				cut = ($urandom_range(0, 149) == 0);
			end
			if (!cut) begin
				offer(mk(CMD_FINISH, 8'($urandom)));
				sent++;
				if ($urandom_range(0, 3) == 0) begin
					offer(mk($urandom_range(0, 1) ? CMD_ABSORB : CMD_FINISH, 8'($urandom)));
					sent++;
				end
			end
			if ($urandom_range(0, 5) == 0)
				drain();
		end

		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
